// ----- hdl/rxyr_pkg.sv -----
// Shared constants, register codes and pipeline structs of the ray/rectangle intersector.
package rxyr_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DW        = 32;
	localparam int UV_BITS   = 16;
	localparam int UVQ_W     = UV_BITS + 1;
	localparam int NUM_W     = DW + FRAC_BITS;
	localparam int REM_W     = DW + 1;
	localparam int PROD_W    = 2 * DW;
	localparam int X_W       = PROD_W - FRAC_BITS + 1;
	localparam int SPAN_W    = DW + 1;
	localparam int REG_IDX_W = 3;
	localparam int ADDR_W    = REG_IDX_W + 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_X_MIN,
		REG_X_MAX,
		REG_Y_MIN,
		REG_Y_MAX,
		REG_PLANE_Z,
		REG_ENABLED
	} reg_idx_t;

	typedef struct packed {
		logic signed [DW-1:0] x_min;
		logic signed [DW-1:0] x_max;
		logic signed [DW-1:0] y_min;
		logic signed [DW-1:0] y_max;
		logic signed [DW-1:0] plane_z;
		logic                 enabled;
	} cfg_t;

	typedef struct packed {
		logic signed [DW-1:0] ox;
		logic signed [DW-1:0] oy;
		logic signed [DW-1:0] oz;
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
		logic signed [DW-1:0] dz;
		logic signed [DW-1:0] tlo;
		logic signed [DW-1:0] thi;
		logic                 fail;
		logic                 neg;
	} ray_side_t;

	typedef struct packed {
		logic signed [DW-1:0] t;
		logic signed [DW-1:0] px;
		logic signed [DW-1:0] py;
		logic signed [DW-1:0] pz;
		logic                 front;
		logic                 fail;
		logic                 x_pos;
		logic                 y_pos;
	} uv_side_t;

endpackage

// ----- hdl/rxyr_ray_if.sv -----
// Ray request channel: valid/ready handshake with origin, direction and t window.
interface rxyr_ray_if;
	logic                              valid;
	logic                              ready;
	logic signed [rxyr_pkg::DW-1:0]    origin_x;
	logic signed [rxyr_pkg::DW-1:0]    origin_y;
	logic signed [rxyr_pkg::DW-1:0]    origin_z;
	logic signed [rxyr_pkg::DW-1:0]    dir_x;
	logic signed [rxyr_pkg::DW-1:0]    dir_y;
	logic signed [rxyr_pkg::DW-1:0]    dir_z;
	logic signed [rxyr_pkg::DW-1:0]    t_min;
	logic signed [rxyr_pkg::DW-1:0]    t_max;

	modport source (
		output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max,
		input  ready
	);
	modport sink (
		input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max,
		output ready
	);
endinterface

// ----- hdl/rxyr_hit_if.sv -----
// Hit result channel: valid/ready handshake with hit flag, t, uv and hit point.
interface rxyr_hit_if;
	logic                              valid;
	logic                              ready;
	logic                              hit;
	logic signed [rxyr_pkg::DW-1:0]    t_hit;
	logic [rxyr_pkg::UVQ_W-1:0]        u_coord;
	logic [rxyr_pkg::UVQ_W-1:0]        v_coord;
	logic signed [rxyr_pkg::DW-1:0]    point_x;
	logic signed [rxyr_pkg::DW-1:0]    point_y;
	logic signed [rxyr_pkg::DW-1:0]    point_z;
	logic                              front_face;

	modport source (
		output valid, hit, t_hit, u_coord, v_coord, point_x, point_y, point_z, front_face,
		input  ready
	);
	modport sink (
		input  valid, hit, t_hit, u_coord, v_coord, point_x, point_y, point_z, front_face,
		output ready
	);
endinterface

// ----- hdl/ray_xy_rect_intersect.sv -----
// Top level: ray against a rectangle in the plane z = k, fully pipelined.
//
// Rays arrive on ray_in (valid/ready); one result per ray leaves on res in
// ray order. Every result carries hit; on a miss all other fields are zero.
// An accepted request passes one prep stage, 33 stages of the t divider
// (overflow check plus one quotient bit per stage), window check, multiply,
// hit point and bounds, uv prep, 17 stages of the uv divider and the output
// register. One ray is taken every cycle while res is not stalled; the
// rate is set by the two pipelined dividers, each retiring one bit per stage.
// The rectangle, plane and enable live in an APB register bank (4-byte
// stride, pready tied high); write it only while no ray is in flight.
// Reset clears every stage valid bit and loads the register reset values.
// When res is stalled with a result waiting, the whole pipeline holds and
// ray_in.ready falls; nothing is dropped or repeated. Bubbles are not
// squeezed out: they travel down the pipeline with the requests.
module ray_xy_rect_intersect (
	input  logic                          clk,
	input  logic                          arst_n,
	rxyr_ray_if.sink                      ray_in,
	rxyr_hit_if.source                    res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rxyr_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	localparam int DW     = rxyr_pkg::DW;
	localparam int F      = rxyr_pkg::FRAC_BITS;
	localparam int X_W    = rxyr_pkg::X_W;
	localparam int SPAN_W = rxyr_pkg::SPAN_W;
	localparam int UVQ_W  = rxyr_pkg::UVQ_W;

	rxyr_pkg::cfg_t cfg;
	logic           adv;

	rxyr_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	// ---- stage 1: numerator and divisor magnitudes
	logic signed [DW:0]            diff;
	logic [DW:0]                   diff_abs;
	logic [DW-1:0]                 den_abs;
	rxyr_pkg::ray_side_t           side_n1;

	logic                          vld_s1;
	logic [rxyr_pkg::NUM_W-1:0]    num_s1;
	logic [DW-1:0]                 den_s1;
	rxyr_pkg::ray_side_t           side_s1;

	assign adv          = !res.valid || res.ready;
	assign ray_in.ready = adv;

	always_comb begin
		diff     = (DW+1)'(cfg.plane_z) - (DW+1)'(ray_in.origin_z);
		diff_abs = diff[DW] ? -diff : diff;
		den_abs  = ray_in.dir_z[DW-1] ? -ray_in.dir_z : ray_in.dir_z;
		side_n1.ox   = ray_in.origin_x;
		side_n1.oy   = ray_in.origin_y;
		side_n1.oz   = ray_in.origin_z;
		side_n1.dx   = ray_in.dir_x;
		side_n1.dy   = ray_in.dir_y;
		side_n1.dz   = ray_in.dir_z;
		side_n1.tlo  = ray_in.t_min;
		side_n1.thi  = ray_in.t_max;
		side_n1.fail = !cfg.enabled || ray_in.dir_z == '0;
		side_n1.neg  = diff[DW] ^ ray_in.dir_z[DW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= ray_in.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1  <= {diff_abs[DW-1:0], {F{1'b0}}};
			den_s1  <= den_abs;
			side_s1 <= side_n1;
		end
	end

	// ---- t divider
	logic                 tq_vld;
	logic [DW-1:0]        tq;
	logic                 tq_ovf;
	rxyr_pkg::ray_side_t  tq_side;

	rxyr_tdiv u_tdiv (
		.clk, .arst_n, .adv,
		.in_valid (vld_s1),
		.in_num   (num_s1),
		.in_den   (den_s1),
		.in_side  (side_s1),
		.out_valid(tq_vld),
		.out_q    (tq),
		.out_ovf  (tq_ovf),
		.out_side (tq_side)
	);

	// ---- stage 2: sign, range and window
	logic                 q_ok;
	logic signed [DW-1:0] t_n;
	logic                 fail_n2;

	logic                 vld_s2;
	logic signed [DW-1:0] t_s2;
	logic                 fail_s2;
	rxyr_pkg::ray_side_t  side_s2;

	always_comb begin
		q_ok    = tq_side.neg ? (!tq[DW-1] || tq[DW-2:0] == '0) : !tq[DW-1];
		t_n     = tq_side.neg ? $signed(-tq) : $signed(tq);
		fail_n2 = tq_side.fail || tq_ovf || !q_ok || t_n < tq_side.tlo || t_n > tq_side.thi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv) vld_s2 <= tq_vld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s2    <= t_n;
			fail_s2 <= fail_n2;
			side_s2 <= tq_side;
		end
	end

	// ---- stage 3: products t * dir
	logic                               vld_s3;
	logic signed [rxyr_pkg::PROD_W-1:0] prod_x_s3;
	logic signed [rxyr_pkg::PROD_W-1:0] prod_y_s3;
	logic signed [rxyr_pkg::PROD_W-1:0] prod_z_s3;
	logic signed [DW-1:0]               t_s3;
	logic                               fail_s3;
	rxyr_pkg::ray_side_t                side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (adv) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_x_s3 <= t_s2 * side_s2.dx;
			prod_y_s3 <= t_s2 * side_s2.dy;
			prod_z_s3 <= t_s2 * side_s2.dz;
			t_s3      <= t_s2;
			fail_s3   <= fail_s2;
			side_s3   <= side_s2;
		end
	end

	// ---- stage 4: hit point and bounds; x and y stay wide so they never wrap
	logic signed [X_W-1:0] x_n;
	logic signed [X_W-1:0] y_n;
	logic signed [DW-1:0]  z_n;
	logic                  out_bounds;

	logic                  vld_s4;
	logic signed [X_W-1:0] x_s4;
	logic signed [X_W-1:0] y_s4;
	logic signed [DW-1:0]  z_s4;
	logic signed [DW-1:0]  t_s4;
	logic                  front_s4;
	logic                  fail_s4;

	always_comb begin
		x_n = X_W'(side_s3.ox) + X_W'(prod_x_s3 >>> F);
		y_n = X_W'(side_s3.oy) + X_W'(prod_y_s3 >>> F);
		z_n = side_s3.oz + DW'(prod_z_s3 >>> F);
		out_bounds = x_n < X_W'(cfg.x_min) || x_n > X_W'(cfg.x_max)
			|| y_n < X_W'(cfg.y_min) || y_n > X_W'(cfg.y_max);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (adv) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s4     <= x_n;
			y_s4     <= y_n;
			z_s4     <= z_n;
			t_s4     <= t_s3;
			front_s4 <= side_s3.dz[DW-1];
			fail_s4  <= fail_s3 || out_bounds;
		end
	end

	// ---- stage 5: offsets and spans for u and v
	logic [SPAN_W-1:0]      span_x;
	logic [SPAN_W-1:0]      span_y;
	rxyr_pkg::uv_side_t     side_n5;

	logic                   vld_s5;
	logic [1:0][SPAN_W-1:0] num_s5;
	logic [1:0][SPAN_W-1:0] den_s5;
	rxyr_pkg::uv_side_t     side_s5;

	always_comb begin
		span_x = {cfg.x_max[DW-1], cfg.x_max} - {cfg.x_min[DW-1], cfg.x_min};
		span_y = {cfg.y_max[DW-1], cfg.y_max} - {cfg.y_min[DW-1], cfg.y_min};
		side_n5.t     = t_s4;
		side_n5.px    = x_s4[DW-1:0];
		side_n5.py    = y_s4[DW-1:0];
		side_n5.pz    = z_s4;
		side_n5.front = front_s4;
		side_n5.fail  = fail_s4;
		side_n5.x_pos = !span_x[SPAN_W-1] && span_x != '0;
		side_n5.y_pos = !span_y[SPAN_W-1] && span_y != '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (adv) vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s5[0] <= x_s4[SPAN_W-1:0] - {cfg.x_min[DW-1], cfg.x_min};
			num_s5[1] <= y_s4[SPAN_W-1:0] - {cfg.y_min[DW-1], cfg.y_min};
			den_s5[0] <= span_x;
			den_s5[1] <= span_y;
			side_s5   <= side_n5;
		end
	end

	// ---- uv divider
	logic                   uv_vld;
	logic [1:0][UVQ_W-1:0]  uv_q;
	rxyr_pkg::uv_side_t     uv_side;

	rxyr_uvdiv u_uvdiv (
		.clk, .arst_n, .adv,
		.in_valid (vld_s5),
		.in_num   (num_s5),
		.in_den   (den_s5),
		.in_side  (side_s5),
		.out_valid(uv_vld),
		.out_q    (uv_q),
		.out_side (uv_side)
	);

	// ---- output register: zero everything on a miss
	logic                 out_vld_q;
	logic                 hit_q;
	logic signed [DW-1:0] t_hit_q;
	logic [UVQ_W-1:0]     u_q;
	logic [UVQ_W-1:0]     v_q;
	logic signed [DW-1:0] px_q;
	logic signed [DW-1:0] py_q;
	logic signed [DW-1:0] pz_q;
	logic                 front_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (adv) out_vld_q <= uv_vld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q   <= !uv_side.fail;
			t_hit_q <= uv_side.fail ? '0 : uv_side.t;
			u_q     <= (uv_side.fail || !uv_side.x_pos) ? '0 : uv_q[0];
			v_q     <= (uv_side.fail || !uv_side.y_pos) ? '0 : uv_q[1];
			px_q    <= uv_side.fail ? '0 : uv_side.px;
			py_q    <= uv_side.fail ? '0 : uv_side.py;
			pz_q    <= uv_side.fail ? '0 : uv_side.pz;
			front_q <= !uv_side.fail && uv_side.front;
		end
	end

	assign res.valid      = out_vld_q;
	assign res.hit        = hit_q;
	assign res.t_hit      = t_hit_q;
	assign res.u_coord    = u_q;
	assign res.v_coord    = v_q;
	assign res.point_x    = px_q;
	assign res.point_y    = py_q;
	assign res.point_z    = pz_q;
	assign res.front_face = front_q;

	// ---- checks
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.hit |-> res.t_hit == '0 && res.u_coord == '0
			&& res.v_coord == '0 && !res.front_face)
		else $error("miss result carries non-zero fields");

	a_uv_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.u_coord <= UVQ_W'(1 << rxyr_pkg::UV_BITS)
			&& res.v_coord <= UVQ_W'(1 << rxyr_pkg::UV_BITS))
		else $error("uv coordinate above one");

	a_hit_in_rect: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.hit |-> res.point_x >= cfg.x_min && res.point_x <= cfg.x_max
			&& res.point_y >= cfg.y_min && res.point_y <= cfg.y_max)
		else $error("hit point outside rectangle");

	a_stall_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid)
		else $error("result lost under stall");
endmodule

// ----- hdl/rxyr_cfg.sv -----
// APB register bank holding the rectangle bounds, plane position and enable.
module rxyr_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rxyr_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output rxyr_pkg::cfg_t                cfg
);
	rxyr_pkg::cfg_t     cfg_q;
	rxyr_pkg::reg_idx_t idx;
	logic               wr_en;

	assign pready = 1'b1;
	assign idx    = rxyr_pkg::reg_idx_t'(paddr[rxyr_pkg::ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_min   <= '0;
			cfg_q.x_max   <= '0;
			cfg_q.y_min   <= '0;
			cfg_q.y_max   <= '0;
			cfg_q.plane_z <= '0;
			cfg_q.enabled <= 1'b1;
		end else if (wr_en) begin
			case (idx)
				rxyr_pkg::REG_X_MIN:   cfg_q.x_min   <= pwdata;
				rxyr_pkg::REG_X_MAX:   cfg_q.x_max   <= pwdata;
				rxyr_pkg::REG_Y_MIN:   cfg_q.y_min   <= pwdata;
				rxyr_pkg::REG_Y_MAX:   cfg_q.y_max   <= pwdata;
				rxyr_pkg::REG_PLANE_Z: cfg_q.plane_z <= pwdata;
				rxyr_pkg::REG_ENABLED: cfg_q.enabled <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			rxyr_pkg::REG_X_MIN:   prdata = cfg_q.x_min;
			rxyr_pkg::REG_X_MAX:   prdata = cfg_q.x_max;
			rxyr_pkg::REG_Y_MIN:   prdata = cfg_q.y_min;
			rxyr_pkg::REG_Y_MAX:   prdata = cfg_q.y_max;
			rxyr_pkg::REG_PLANE_Z: prdata = cfg_q.plane_z;
			rxyr_pkg::REG_ENABLED: prdata = 32'(cfg_q.enabled);
			default:               prdata = '0;
		endcase
	end
endmodule

// ----- hdl/rxyr_tdiv.sv -----
// Pipelined restoring divider for t: one quotient bit per stage, overflow check up front.
module rxyr_tdiv (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_valid,
	input  logic [rxyr_pkg::NUM_W-1:0]        in_num,
	input  logic [rxyr_pkg::DW-1:0]           in_den,
	input  rxyr_pkg::ray_side_t               in_side,
	output logic                              out_valid,
	output logic [rxyr_pkg::DW-1:0]           out_q,
	output logic                              out_ovf,
	output rxyr_pkg::ray_side_t               out_side
);
	localparam int N     = rxyr_pkg::DW;
	localparam int REM_W = rxyr_pkg::REM_W;

	logic                vld_s  [0:N];
	logic [REM_W-1:0]    rem_s  [0:N-1];
	logic [N-1:0]        lo_s   [0:N-1];
	logic [N-1:0]        q_s    [0:N];
	logic [N-1:0]        den_s  [0:N-1];
	logic                ovf_s  [0:N];
	rxyr_pkg::ray_side_t side_s [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= N; k++) vld_s[k] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k <= N; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// quotient fits 32 bits only when the high part of the dividend is below the divisor
	always_ff @(posedge clk) begin
		if (adv) begin
			ovf_s[0]  <= N'(in_num[rxyr_pkg::NUM_W-1:N]) >= in_den;
			rem_s[0]  <= REM_W'(in_num[rxyr_pkg::NUM_W-1:N]);
			lo_s[0]   <= in_num[N-1:0];
			q_s[0]    <= '0;
			den_s[0]  <= in_den;
			side_s[0] <= in_side;
		end
	end

	for (genvar k = 1; k <= N; k++) begin : g_step
		logic [REM_W-1:0] r2;
		logic             ge;

		always_comb begin
			r2 = {rem_s[k-1][REM_W-2:0], lo_s[k-1][N-1]};
			ge = r2 >= {1'b0, den_s[k-1]};
		end

		if (k < N) begin : g_mid
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[k] <= ge ? r2 - {1'b0, den_s[k-1]} : r2;
					lo_s[k]  <= {lo_s[k-1][N-2:0], 1'b0};
					den_s[k] <= den_s[k-1];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				q_s[k]    <= {q_s[k-1][N-2:0], ge};
				ovf_s[k]  <= ovf_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[N];
	assign out_q     = q_s[N];
	assign out_ovf   = ovf_s[N];
	assign out_side  = side_s[N];
endmodule

// ----- hdl/rxyr_uvdiv.sv -----
// Two-lane pipelined divider for the u and v fractions, one quotient bit per stage.
module rxyr_uvdiv (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   adv,
	input  logic                                   in_valid,
	input  logic [1:0][rxyr_pkg::SPAN_W-1:0]       in_num,
	input  logic [1:0][rxyr_pkg::SPAN_W-1:0]       in_den,
	input  rxyr_pkg::uv_side_t                     in_side,
	output logic                                   out_valid,
	output logic [1:0][rxyr_pkg::UVQ_W-1:0]        out_q,
	output rxyr_pkg::uv_side_t                     out_side
);
	localparam int S = rxyr_pkg::UVQ_W;
	localparam int W = rxyr_pkg::SPAN_W;

	logic                     vld_s  [0:S-1];
	logic [1:0][W-1:0]        rem_s  [0:S-2];
	logic [1:0][W-1:0]        den_s  [0:S-2];
	logic [1:0][S-1:0]        q_s    [0:S-1];
	rxyr_pkg::uv_side_t       side_s [0:S-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < S; k++) vld_s[k] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < S; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// first stage takes the integer bit without a shift, the rest one fraction bit each
	for (genvar k = 0; k < S; k++) begin : g_step
		logic [1:0][W-1:0] rem_in;
		logic [1:0][W-1:0] den_in;
		logic [1:0][S-1:0] q_in;
		logic [1:0][W:0]   r2;
		logic [1:0][W:0]   r2_sub;
		logic [1:0]        ge;
		rxyr_pkg::uv_side_t side_in;

		if (k == 0) begin : g_first
			assign rem_in  = in_num;
			assign den_in  = in_den;
			assign q_in    = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign den_in  = den_s[k-1];
			assign q_in    = q_s[k-1];
			assign side_in = side_s[k-1];
		end

		always_comb begin
			for (int l = 0; l < 2; l++) begin
				r2[l]     = (k == 0) ? {1'b0, rem_in[l]} : {rem_in[l], 1'b0};
				ge[l]     = r2[l] >= {1'b0, den_in[l]};
				r2_sub[l] = r2[l] - {1'b0, den_in[l]};
			end
		end

		if (k < S - 1) begin : g_mid
			always_ff @(posedge clk) begin
				if (adv) begin
					for (int l = 0; l < 2; l++)
						rem_s[k][l] <= ge[l] ? r2_sub[l][W-1:0] : r2[l][W-1:0];
					den_s[k] <= den_in;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int l = 0; l < 2; l++) q_s[k][l] <= {q_in[l][S-2:0], ge[l]};
				side_s[k] <= side_in;
			end
		end
	end

	assign out_valid = vld_s[S-1];
	assign out_q     = q_s[S-1];
	assign out_side  = side_s[S-1];
endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for the ray/rectangle intersector: directed, random and stall tests.
module tb_top;
	localparam int DW        = rxyr_pkg::DW;
	localparam int UVQ_W     = rxyr_pkg::UVQ_W;
	localparam int ADDR_W    = rxyr_pkg::ADDR_W;
	localparam int FRAC_BITS = rxyr_pkg::FRAC_BITS;

	typedef struct {
		logic signed [DW-1:0] ox, oy, oz, dx, dy, dz, tlo, thi;
	} ray_t;

	typedef struct {
		logic                 hit;
		logic signed [DW-1:0] t, px, py, pz;
		logic [UVQ_W-1:0]     u, v;
		logic                 front;
	} hit_res_t;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 80;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	rxyr_ray_if ray_ch ();
	rxyr_hit_if res_ch ();

	ray_xy_rect_intersect u_dut (
		.clk(clk), .arst_n(arst_n), .ray_in(ray_ch), .res(res_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// rectangle settings as the bench believes them
	longint rect_xlo, rect_xhi, rect_ylo, rect_yhi, rect_z;
	bit     rect_on;

	hit_res_t expected_hits[$];
	int  errors;
	int  sink_hold_req;
	bit  no_idle;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic hit_res_t trace_ray(ray_t r);
		hit_res_t res;
		longint t, x, y, z, ox, oy, oz, dz;
		res = '{default: '0};
		ox = r.ox;
		oy = r.oy;
		oz = r.oz;
		dz = r.dz;
		if (!rect_on || dz == 0) return res;
		t = ((rect_z - oz) * 65536) / dz;
		if (t < -64'sd2147483648 || t > 64'sd2147483647) return res;
		if (t < longint'(r.tlo) || t > longint'(r.thi)) return res;
		x = ox + ((t * longint'(r.dx)) >>> FRAC_BITS);
		y = oy + ((t * longint'(r.dy)) >>> FRAC_BITS);
		if (x < rect_xlo || x > rect_xhi || y < rect_ylo || y > rect_yhi) return res;
		z = oz + ((t * dz) >>> FRAC_BITS);
		res.hit   = 1'b1;
		res.t     = t[31:0];
		res.px    = x[31:0];
		res.py    = y[31:0];
		res.pz    = z[31:0];
		res.u     = (rect_xhi > rect_xlo) ?
			UVQ_W'(((x - rect_xlo) * 65536) / (rect_xhi - rect_xlo)) : '0;
		res.v     = (rect_yhi > rect_ylo) ?
			UVQ_W'(((y - rect_ylo) * 65536) / (rect_yhi - rect_ylo)) : '0;
		res.front = (dz < 0);
		return res;
	endfunction

	// setup and access phases, then idle before the next write
	task automatic reg_write(rxyr_pkg::reg_idx_t idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(idx) << 2;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			rxyr_pkg::REG_X_MIN:   rect_xlo = longint'(signed'(val));
			rxyr_pkg::REG_X_MAX:   rect_xhi = longint'(signed'(val));
			rxyr_pkg::REG_Y_MIN:   rect_ylo = longint'(signed'(val));
			rxyr_pkg::REG_Y_MAX:   rect_yhi = longint'(signed'(val));
			rxyr_pkg::REG_PLANE_Z: rect_z   = longint'(signed'(val));
			rxyr_pkg::REG_ENABLED: rect_on  = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// drop valid first so the last request is not taken again
	task automatic wait_drained();
		ray_ch.valid <= 1'b0;
		while (expected_hits.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_rect(int xlo, int xhi, int ylo, int yhi, int z, bit on);
		wait_drained();
		ray_ch.valid <= 1'b0;
		reg_write(rxyr_pkg::REG_X_MIN, xlo);
		reg_write(rxyr_pkg::REG_X_MAX, xhi);
		reg_write(rxyr_pkg::REG_Y_MIN, ylo);
		reg_write(rxyr_pkg::REG_Y_MAX, yhi);
		reg_write(rxyr_pkg::REG_PLANE_Z, z);
		reg_write(rxyr_pkg::REG_ENABLED, on);
	endtask

	// valid stays high between back-to-back requests
	task automatic send_ray(ray_t r);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			ray_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		ray_ch.valid    <= 1'b1;
		ray_ch.origin_x <= r.ox;
		ray_ch.origin_y <= r.oy;
		ray_ch.origin_z <= r.oz;
		ray_ch.dir_x    <= r.dx;
		ray_ch.dir_y    <= r.dy;
		ray_ch.dir_z    <= r.dz;
		ray_ch.t_min    <= r.tlo;
		ray_ch.t_max    <= r.thi;
		@(posedge clk);
		while (!ray_ch.ready) @(posedge clk);
		expected_hits.push_back(trace_ray(r));
	endtask

	function automatic logic [31:0] rnd_word();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			3: return $urandom_range(0, 255) - 128;
			default: return $urandom;
		endcase
	endfunction

	function automatic ray_t noise_ray();
		ray_t r;
		r.ox = rnd_word(); r.oy = rnd_word(); r.oz = rnd_word();
		r.dx = rnd_word(); r.dy = rnd_word(); r.dz = rnd_word();
		r.tlo = rnd_word(); r.thi = rnd_word();
		return r;
	endfunction

	function automatic longint pick_in(longint lo, longint hi);
		longint span;
		if (hi < lo) return lo;
		span = hi - lo + 1;
		return lo + longint'({$urandom, $urandom} & 64'h7fff_ffff_ffff_ffff) % span;
	endfunction

	function automatic longint rnd_dir(int mag);
		longint d;
		d = $urandom_range(1, mag);
		return $urandom_range(0, 1) ? -d : d;
	endfunction

	// aim at a point on the rectangle and walk back along the ray
	function automatic ray_t aimed_ray();
		ray_t r;
		longint t, dx, dy, dz, px, py;
		t  = $urandom_range(1 << 10, 8 << 16);
		dz = rnd_dir(1 << 18);
		dx = rnd_dir(1 << 18);
		dy = rnd_dir(1 << 18);
		px = pick_in(rect_xlo, rect_xhi);
		py = pick_in(rect_ylo, rect_yhi);
		r.dx = dx; r.dy = dy; r.dz = dz;
		r.oz = rect_z - ((t * dz) >>> FRAC_BITS);
		r.ox = px - ((t * dx) >>> FRAC_BITS);
		r.oy = py - ((t * dy) >>> FRAC_BITS);
		case ($urandom_range(0, 5))
			0: begin r.tlo = t - $urandom_range(0, 4); r.thi = t + $urandom_range(0, 4); end
			1: begin r.tlo = t + $urandom_range(1, 64); r.thi = t + 1000; end
			default: begin r.tlo = '0; r.thi = 32'h7fff_ffff; end
		endcase
		return r;
	endfunction

	task automatic run_mix(int count);
		repeat (count) send_ray(($urandom_range(0, 4) != 0) ? aimed_ray() : noise_ray());
	endtask

	task automatic test_directed();
		ray_t r;
		set_rect(-(4 << 16), 4 << 16, -(2 << 16), 2 << 16, 10 << 16, 1'b1);
		// straight down onto the centre, and straight up from behind
		r = '{0, 0, 20 << 16, 0, 0, -(1 << 16), 0, 32'h7fff_ffff};
		send_ray(r);
		r = '{1 << 16, 1 << 16, 0, 0, 0, 1 << 16, 0, 32'h7fff_ffff};
		send_ray(r);
		// corners hit exactly
		r = '{-(4 << 16), 2 << 16, 0, 0, 0, 1 << 16, 0, 32'h7fff_ffff};
		send_ray(r);
		r = '{4 << 16, -(2 << 16), 0, 0, 0, 1 << 16, 0, 32'h7fff_ffff};
		send_ray(r);
		// parallel ray
		r = '{0, 0, 0, 1 << 16, 0, 0, 32'h8000_0000, 32'h7fff_ffff};
		send_ray(r);
		// quotient overflow
		r = '{0, 0, 32'h8000_0000, 0, 0, 1, 32'h8000_0000, 32'h7fff_ffff};
		send_ray(r);
		// window: below, above, inverted, exact both ends
		r = '{0, 0, 0, 0, 0, 1 << 16, 11 << 16, 12 << 16};
		send_ray(r);
		r = '{0, 0, 0, 0, 0, 1 << 16, 0, 9 << 16};
		send_ray(r);
		r = '{0, 0, 0, 0, 0, 1 << 16, 12 << 16, 1 << 16};
		send_ray(r);
		r = '{0, 0, 0, 0, 0, 1 << 16, 10 << 16, 10 << 16};
		send_ray(r);
		// beyond x and beyond y
		r = '{5 << 16, 0, 0, 0, 0, 1 << 16, 0, 32'h7fff_ffff};
		send_ray(r);
		r = '{0, -(3 << 16), 0, 0, 0, 1 << 16, 0, 32'h7fff_ffff};
		send_ray(r);
		// extreme field values
		r = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
		send_ray(r);
		r = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
		send_ray(r);
		// zero-width rectangle
		set_rect(3 << 16, 3 << 16, 1 << 16, 1 << 16, 0, 1'b1);
		r = '{3 << 16, 1 << 16, 5 << 16, 0, 0, -(1 << 16), 0, 32'h7fff_ffff};
		send_ray(r);
		// disabled
		set_rect(-(4 << 16), 4 << 16, -(2 << 16), 2 << 16, 10 << 16, 1'b0);
		r = '{0, 0, 20 << 16, 0, 0, -(1 << 16), 0, 32'h7fff_ffff};
		send_ray(r);
	endtask

	task automatic test_random();
		set_rect(-(16 << 16), 16 << 16, -(8 << 16), 8 << 16, 3 << 16, 1'b1);
		run_mix(200);
		set_rect(-(1 << 23), 1 << 23, -(1 << 22), 1 << 22, -(1 << 23), 1'b1);
		run_mix(150);
		set_rect(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
		run_mix(150);
		set_rect(5 << 16, 5 << 16, -(1 << 16), 7 << 16, 32'h8000_0000, 1'b1);
		run_mix(100);
		set_rect(2 << 16, 1 << 16, 0, 1, 0, 1'b1);
		run_mix(80);
		set_rect(-(16 << 16), 16 << 16, -(8 << 16), 8 << 16, 0, 1'b0);
		run_mix(80);
		no_idle = 1'b1;
		set_rect(-(64 << 16), 64 << 16, -(64 << 16), 64 << 16, 1 << 16, 1'b1);
		run_mix(120);
		no_idle = 1'b0;
	endtask

	task automatic test_stalls();
		// long receiver hold-off while requests keep coming
		sink_hold_req = 400;
		no_idle = 1'b1;
		run_mix(150);
		no_idle = 1'b0;
		// pause until everything has come back, then resume
		wait_drained();
		run_mix(60);
	endtask

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	// result sink: random ready, long hold-off on request
	initial begin
		int gap, hold;
		hit_res_t want;
		gap = 0;
		hold = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready) begin
				if (expected_hits.size() == 0) begin
					errors++;
					$display("%0t: result with no request outstanding, hit %0b", $time,
						res_ch.hit);
				end else begin
					want = expected_hits.pop_front();
					check_field("hit", want.hit, res_ch.hit);
					check_field("t_hit", want.t, res_ch.t_hit);
					check_field("u_coord", want.u, res_ch.u_coord);
					check_field("v_coord", want.v, res_ch.v_coord);
					check_field("point_x", want.px, res_ch.point_x);
					check_field("point_y", want.py, res_ch.point_y);
					check_field("point_z", want.pz, res_ch.point_z);
					check_field("front_face", want.front, res_ch.front_face);
				end
			end
			if (sink_hold_req > 0) begin
				hold = sink_hold_req;
				sink_hold_req = 0;
			end
			if (hold > 0) begin
				hold--;
				res_ch.ready <= 1'b0;
			end else if (gap > 0) begin
				gap--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				gap = idle_len();
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((ray_ch.valid && ray_ch.ready) || (res_ch.valid && res_ch.ready) || psel)
				idle = 0;
			else
				idle++;
			if (idle >= WATCHDOG_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		errors = 0;
		sink_hold_req = 0;
		no_idle = 1'b0;
		rect_xlo = 0; rect_xhi = 0; rect_ylo = 0; rect_yhi = 0; rect_z = 0;
		rect_on = 1'b1;
		arst_n <= 1'b0;
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
		ray_ch.valid <= 1'b0;
		ray_ch.origin_x <= '0; ray_ch.origin_y <= '0; ray_ch.origin_z <= '0;
		ray_ch.dir_x <= '0; ray_ch.dir_y <= '0; ray_ch.dir_z <= '0;
		ray_ch.t_min <= '0; ray_ch.t_max <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_random();
		test_stalls();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_hits.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

// ----- filelist.f -----
hdl/rxyr_pkg.sv
hdl/rxyr_ray_if.sv
hdl/rxyr_hit_if.sv
hdl/rxyr_cfg.sv
hdl/rxyr_tdiv.sv
hdl/rxyr_uvdiv.sv
hdl/ray_xy_rect_intersect.sv
tb/tb_top.sv
